// ===== rtl/sic_pkg.sv =====
// sic_pkg: sizes, register codes, neighbor steps, controller states and the
// command/status structs shared by the sub-island counter modules.
// No dependencies.
`default_nettype none

package sic_pkg;

    // grid limits
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int CELL_CAP = MAX_ROWS * MAX_COLS;

    // derived widths
    localparam int ADDR_W  = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
    localparam int CELLS_W = $clog2(CELL_CAP + 1);
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W  = $clog2(MAX_COLS + 1);
    localparam int STK_W   = ROW_W + COL_W;
    localparam int SP_W    = CELLS_W;

    // map entry layout: reference land above candidate land
    localparam int MAP_W     = 2;
    localparam int MAP_A_BIT = 1;
    localparam int MAP_B_BIT = 0;

    // configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    localparam int ROWS_RESET = (64 > MAX_ROWS) ? MAX_ROWS : 64;
    localparam int COLS_RESET = (64 > MAX_COLS) ? MAX_COLS : 64;

    // result
    localparam int COUNT_W = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // neighbor directions: up, left, down, right
    localparam int DIR_W = 2;
    localparam logic [DIR_W-1:0] DIR_LAST = 2'd3;
    localparam logic signed [1:0] STEP_ROW [4] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0};
    localparam logic signed [1:0] STEP_COL [4] = '{2'sd0, -2'sd1, 2'sd0, 2'sd1};

    // register value limited to 1..hi
    function automatic int clamp_size(logic [CFG_W-1:0] v, int hi);
        int r;
        r = int'(v);
        if (r < 1)
        begin
            r = 1;
        end
        else if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // controller states
    typedef enum logic [8:0] {
        S_LOAD     = 9'b000000001,
        S_SCAN_RD  = 9'b000000010,
        S_SCAN_CHK = 9'b000000100,
        S_POP      = 9'b000001000,
        S_POP_WAIT = 9'b000010000,
        S_NB_ADDR  = 9'b000100000,
        S_NB_RD    = 9'b001000000,
        S_NB_CHK   = 9'b010000000,
        S_EMIT     = 9'b100000000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // input item taken, store the cell pair
        logic frame_end;   // last cell taken, start the scan
        logic sel_scan;    // map read at scan position
        logic scan_hit;    // scan found land: clear, push, start island
        logic scan_next;   // advance scan position
        logic island_end;  // island finished, count it if contained
        logic pop;         // pop top of stack
        logic cur_load;    // take popped cell as current
        logic nb_latch;    // latch neighbor coordinates and address
        logic nb_hit;      // neighbor is land: clear and push
        logic dir_next;    // next neighbor direction
        logic emit;        // move count into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cell_b;      // candidate land bit of last map read
        logic scan_last;   // scan position is the last cell
        logic stack_empty;
        logic stack_full;
        logic nb_ok;       // current neighbor lies inside the grid
        logic dir_last;    // last neighbor direction
        logic out_busy;    // output register holds an untaken result
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/sic_if.sv =====
// sic_if: valid/ready channels of the sub-island counter, cell pairs in and
// island count out. No dependencies.
`default_nettype none

// cell pair channel
interface sic_cell_if;
    logic valid;
    logic ready;
    logic land_a;
    logic land_b;
    logic last_cell;

    modport source (output valid, output land_a, output land_b, output last_cell,
                    input ready);
    modport sink (input valid, input land_a, input land_b, input last_cell,
                  output ready);
endinterface

// count channel
interface sic_count_if;
    logic        valid;
    logic        ready;
    logic [11:0] sub_island_count;

    modport source (output valid, output sub_island_count, input ready);
    modport sink (input valid, input sub_island_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/sub_island_counter.sv =====
// sub_island_counter: top level, joins controller and datapath to the cell and
// count channels and the register port. Depends on sic_pkg, sic_if, sic_ctrl
// and sic_dp.
//
//   channel    dir  signals                               when taken
//   cell_in    in   valid ready land_a land_b last_cell   valid & ready
//   count_out  out  valid ready sub_island_count          valid & ready
//   cfg        in   cfg_wr_en cfg_index cfg_data          cfg_wr_en high
//
// Cells load at one per cycle. After the last cell the raster scan reads and
// checks each cell in turn. Each island cell is popped from the stack, then
// each neighbor has its address formed and, if it lies in the grid, is read
// from the map memory (whose read is registered) and checked; an empty stack
// closes the island. The result passes through the emit state into the
// output register; the next frame loads while it waits to be taken.
// Reset clears the control state; map and stack contents need no clearing.
`default_nettype none

module sub_island_counter
    import sic_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    sic_cell_if.sink                  cell_in,
    sic_count_if.source               count_out
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign cell_in.ready = in_ready;

    // sequencer
    sic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cell_in.valid),
        .in_last  (cell_in.last_cell),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage and arithmetic
    sic_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .land_a           (cell_in.land_a),
        .land_b           (cell_in.land_b),
        .out_ready        (count_out.ready),
        .out_valid        (count_out.valid),
        .sub_island_count (count_out.sub_island_count),
        .cmd              (cmd),
        .sts              (sts)
    );

    // a cell is stored only on an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (cell_in.valid && cell_in.ready))
        else $error("cell stored without an accepted item");

    // no item taken in the cycle after the last cell
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.frame_end |=> !cell_in.ready)
        else $error("input still ready after the last cell");

    // the stack never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_hit || cmd.nb_hit) |-> !sts.stack_full)
        else $error("push onto a full stack");

    // a new count never overwrites one that is not yet taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !count_out.valid)
        else $error("count overwritten before it was taken");

endmodule

`default_nettype wire

// ===== rtl/sic_ram.sv =====
// sic_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sic_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/sic_ctrl.sv =====
// sic_ctrl: state machine of the sub-island counter: loading, raster scan,
// flood fill over the stack and result hand-off. Depends on sic_pkg.
`default_nettype none

module sic_ctrl
    import sic_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_last,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && in_last)
                begin
                    cmd.frame_end = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.sel_scan = 1'b1;
                state_next   = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.sel_scan = 1'b1;
                if (sts.cell_b)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = S_POP;
                end
                else if (sts.scan_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_POP:
            begin
                if (sts.stack_empty)
                begin
                    cmd.island_end = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.scan_next = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                cmd.cur_load = 1'b1;
                state_next   = S_NB_ADDR;
            end
            S_NB_ADDR:
            begin
                cmd.nb_latch = 1'b1;
                if (sts.nb_ok)
                begin
                    state_next = S_NB_RD;
                end
                else if (sts.dir_last)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.dir_next = 1'b1;
                end
            end
            S_NB_RD:
            begin
                state_next = S_NB_CHK;
            end
            S_NB_CHK:
            begin
                cmd.nb_hit = sts.cell_b;
                if (sts.dir_last)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cmd.dir_next = 1'b1;
                    state_next   = S_NB_ADDR;
                end
            end
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sic_dp.sv =====
// sic_dp: datapath of the sub-island counter: grid registers, cell map and
// stack memories, scan and neighbor address logic, island count and output
// register. Depends on sic_pkg and sic_ram.
`default_nettype none

module sic_dp
    import sic_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 land_a,
    input  wire logic                 land_b,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic      [COUNT_W-1:0]   sub_island_count,
    input  wire cmd_t                 cmd,
    output sts_t                      sts
);

    // grid size registers
    logic [RCNT_W-1:0]        rows_reg, rows_next;
    logic [CCNT_W-1:0]        cols_reg, cols_next;
    logic [CELLS_W-1:0]       cells_reg;
    logic [RCNT_W+CCNT_W-1:0] cells_prod;

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_wr_en && cfg_index == REG_GRID_ROWS)
        begin
            rows_next = RCNT_W'(clamp_size(cfg_data, MAX_ROWS));
        end
        if (cfg_wr_en && cfg_index == REG_GRID_COLS)
        begin
            cols_next = CCNT_W'(clamp_size(cfg_data, MAX_COLS));
        end
    end

    assign cells_prod = rows_next * cols_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= RCNT_W'(ROWS_RESET);
            cols_reg  <= CCNT_W'(COLS_RESET);
            cells_reg <= CELLS_W'(ROWS_RESET * COLS_RESET);
        end
        else
        begin
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            cells_reg <= cells_prod[CELLS_W-1:0];
        end
    end

    // load pointer
    logic [CELLS_W-1:0] ptr_reg;
    logic               load_ok;

    assign load_ok = ptr_reg < cells_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.frame_end)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.load && load_ok)
        begin
            ptr_reg <= ptr_reg + CELLS_W'(1);
        end
    end

    // raster scan position
    logic [ADDR_W-1:0] scan_p_reg;
    logic [ROW_W-1:0]  scan_r_reg;
    logic [COL_W-1:0]  scan_c_reg;
    logic              col_end;

    assign col_end = (CCNT_W'(scan_c_reg) + CCNT_W'(1)) == cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_p_reg <= '0;
            scan_r_reg <= '0;
            scan_c_reg <= '0;
        end
        else if (cmd.frame_end)
        begin
            scan_p_reg <= '0;
            scan_r_reg <= '0;
            scan_c_reg <= '0;
        end
        else if (cmd.scan_next)
        begin
            scan_p_reg <= scan_p_reg + ADDR_W'(1);
            if (col_end)
            begin
                scan_c_reg <= '0;
                scan_r_reg <= scan_r_reg + ROW_W'(1);
            end
            else
            begin
                scan_c_reg <= scan_c_reg + COL_W'(1);
            end
        end
    end

    // current cell and neighbor direction
    logic [ROW_W-1:0] cur_r_reg;
    logic [COL_W-1:0] cur_c_reg;
    logic [DIR_W-1:0] dir_reg;
    logic [STK_W-1:0] stk_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= '0;
        end
        else if (cmd.cur_load)
        begin
            dir_reg <= '0;
        end
        else if (cmd.dir_next)
        begin
            dir_reg <= dir_reg + DIR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cur_load)
        begin
            cur_r_reg <= stk_rdata[STK_W-1:COL_W];
            cur_c_reg <= stk_rdata[COL_W-1:0];
        end
    end

    // neighbor coordinates, bounds and address
    logic signed [ROW_W+1:0]    nr_ext;
    logic signed [COL_W+1:0]    nc_ext;
    logic                       row_ok, col_ok;
    logic [ROW_W-1:0]           nr_val;
    logic [COL_W-1:0]           nc_val;
    logic [ROW_W+CCNT_W:0]      nb_sum;
    logic [ROW_W-1:0]           nr_reg;
    logic [COL_W-1:0]           nc_reg;
    logic [ADDR_W-1:0]          addr_reg;

    assign nr_ext = $signed({2'b00, cur_r_reg}) + (ROW_W+2)'(STEP_ROW[dir_reg]);
    assign nc_ext = $signed({2'b00, cur_c_reg}) + (COL_W+2)'(STEP_COL[dir_reg]);
    assign row_ok = !nr_ext[ROW_W+1] && (nr_ext[ROW_W:0] < (ROW_W+1)'(rows_reg));
    assign col_ok = !nc_ext[COL_W+1] && (nc_ext[COL_W:0] < (COL_W+1)'(cols_reg));
    assign nr_val = nr_ext[ROW_W-1:0];
    assign nc_val = nc_ext[COL_W-1:0];
    assign nb_sum = nr_val * cols_reg + nc_val;

    always_ff @(posedge clk)
    begin
        if (cmd.nb_latch)
        begin
            nr_reg   <= nr_val;
            nc_reg   <= nc_val;
            addr_reg <= nb_sum[ADDR_W-1:0];
        end
    end

    // cell map memory: reference and candidate bit per cell
    logic              map_we;
    logic [ADDR_W-1:0] map_waddr;
    logic [MAP_W-1:0]  map_wdata;
    logic [ADDR_W-1:0] map_raddr;
    logic [MAP_W-1:0]  map_rdata;

    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = addr_reg;
        map_wdata = {map_rdata[MAP_A_BIT], 1'b0};
        if (cmd.load)
        begin
            map_we    = load_ok;
            map_waddr = ptr_reg[ADDR_W-1:0];
            map_wdata = {land_a, land_b};
        end
        else if (cmd.scan_hit)
        begin
            map_we    = 1'b1;
            map_waddr = scan_p_reg;
        end
        else if (cmd.nb_hit)
        begin
            map_we = 1'b1;
        end
    end

    assign map_raddr = cmd.sel_scan ? scan_p_reg : addr_reg;

    sic_ram #(
        .WIDTH (MAP_W),
        .DEPTH (CELL_CAP)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // search stack of row/column pairs
    logic [SP_W-1:0]  sp_reg;
    logic [SP_W-1:0]  sp_dec;
    logic             push;
    logic [STK_W-1:0] push_data;

    assign sp_dec    = sp_reg - SP_W'(1);
    assign push      = cmd.scan_hit || cmd.nb_hit;
    assign push_data = cmd.scan_hit ? {scan_r_reg, scan_c_reg} : {nr_reg, nc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else if (push)
        begin
            sp_reg <= sp_reg + SP_W'(1);
        end
        else if (cmd.pop)
        begin
            sp_reg <= sp_dec;
        end
    end

    sic_ram #(
        .WIDTH (STK_W),
        .DEPTH (CELL_CAP)
    ) u_stack (
        .clk   (clk),
        .we    (push),
        .waddr (sp_reg[ADDR_W-1:0]),
        .wdata (push_data),
        .raddr (sp_dec[ADDR_W-1:0]),
        .rdata (stk_rdata)
    );

    // containment flag and island count
    logic               contained_reg;
    logic [COUNT_W-1:0] total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contained_reg <= 1'b1;
            total_reg     <= '0;
        end
        else
        begin
            if (cmd.scan_hit)
            begin
                contained_reg <= map_rdata[MAP_A_BIT];
            end
            else if (cmd.nb_hit)
            begin
                contained_reg <= contained_reg & map_rdata[MAP_A_BIT];
            end
            if (cmd.frame_end)
            begin
                total_reg <= '0;
            end
            else if (cmd.island_end && contained_reg && total_reg != COUNT_MAX)
            begin
                total_reg <= total_reg + COUNT_W'(1);
            end
        end
    end

    // output register
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_count_reg <= total_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign sub_island_count = out_count_reg;

    // status
    assign sts.cell_b      = map_rdata[MAP_B_BIT];
    assign sts.scan_last   = (CELLS_W'(scan_p_reg) + CELLS_W'(1)) == cells_reg;
    assign sts.stack_empty = sp_reg == '0;
    assign sts.stack_full  = sp_reg == SP_W'(CELL_CAP);
    assign sts.nb_ok       = row_ok && col_ok;
    assign sts.dir_last    = dir_reg == DIR_LAST;
    assign sts.out_busy    = out_valid_reg;

endmodule

`default_nettype wire
